@@ hdl/amac_pkg.sv @@
// shared constants, command and status types for the moving average calibrator
package amac_pkg;

   localparam int unsigned RAW_W          = 24;
   localparam int unsigned CFG_W          = 32;
   localparam int unsigned OUT_W          = 32;
   localparam int unsigned Q_FRAC         = 8;
   localparam int unsigned SCALE_FRAC     = 24;
   localparam int unsigned CSR_IDX_W      = 8;
   localparam int unsigned DEFAULT_WINDOW = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_CAL_OFFSET = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_SCALE  = CSR_IDX_W'(1);

   localparam logic signed [CFG_W-1:0] CAL_OFFSET_RESET = '0;
   localparam logic signed [CFG_W-1:0] CAL_SCALE_RESET  = 32'sh0100_0000;

   typedef struct packed {
      logic capture;
      logic update;
      logic div_init;
      logic div_step;
      logic apply_sign;
      logic mul;
      logic add;
      logic out_load;
   } amac_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } amac_status_type;

endpackage

@@ hdl/amac_if.sv @@
// channel interfaces for request, response and register write transactions
interface amac_req_if;
   import amac_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_code;
   logic             timed_out;
   modport source (output valid, raw_code, timed_out, input ready);
   modport sink (input valid, raw_code, timed_out, output ready);
endinterface

interface amac_rsp_if;
   import amac_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    ok;
   logic signed [RAW_W-1:0] sample_value;
   logic signed [OUT_W-1:0] filtered_q8;
   logic signed [OUT_W-1:0] pressure_q8;
   modport source (output valid, ok, sample_value, filtered_q8, pressure_q8, input ready);
   modport sink (input valid, ok, sample_value, filtered_q8, pressure_q8, output ready);
endinterface

interface amac_csr_if;
   import amac_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/adc_moving_average_calibrate.sv @@
// top level of the moving average calibrator for a 24-bit pressure converter
// Each request transaction carries one two's complement converter code and a timeout flag.
// A timed out transaction returns ok low with zero fields and leaves the ring and sum untouched.
// Otherwise the code enters a ring of the last WINDOW samples, the running sum and fill
// count are updated, and the response gives the mean of the filled entries in Q.8
// (truncated toward zero) and offset plus mean times scale in Q.8, saturated to 32 bits.
// The mean comes from a restoring divider that produces one quotient bit per cycle over
// 32 + clog2(WINDOW) bits; a timed out sample skips the divider and goes straight to its
// response. One transaction is in progress at a time and the next request is accepted
// from the cycle after the response is loaded; the response register lets the next
// request be accepted while the previous response waits.
// Register writes are taken every cycle.
module adc_moving_average_calibrate #(
   parameter int unsigned WINDOW = amac_pkg::DEFAULT_WINDOW
) (
   input logic        clock,
   input logic        reset,
   amac_req_if.sink   req_chan,
   amac_rsp_if.source rsp_chan,
   amac_csr_if.sink   csr_chan
);
   import amac_pkg::*;

   amac_cmd_type    cmd;
   amac_status_type status;

   assign csr_chan.ready = 1'b1;

   amac_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_timed_out (req_chan.timed_out),
      .req_ready     (req_chan.ready),
      .cmd           (cmd),
      .status        (status)
   );

   amac_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_raw_code     (req_chan.raw_code),
      .req_timed_out    (req_chan.timed_out),
      .csr_we           (csr_chan.valid),
      .csr_index        (csr_chan.index),
      .csr_data         (csr_chan.data),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_ok           (rsp_chan.ok),
      .rsp_sample_value (rsp_chan.sample_value),
      .rsp_filtered_q8  (rsp_chan.filtered_q8),
      .rsp_pressure_q8  (rsp_chan.pressure_q8)
   );

endmodule

@@ hdl/amac_ctrl.sv @@
// sequencing state machine for one transaction of the moving average calibrator
module amac_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_timed_out,
   output logic                      req_ready,
   output amac_pkg::amac_cmd_type    cmd,
   input  amac_pkg::amac_status_type status
);
   import amac_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_UPDATE   = 8'b0000_0010,
      ST_DIV_INIT = 8'b0000_0100,
      ST_DIV      = 8'b0000_1000,
      ST_SIGN     = 8'b0001_0000,
      ST_MUL      = 8'b0010_0000,
      ST_ADD      = 8'b0100_0000,
      ST_FINISH   = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_timed_out ? ST_FINISH : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            cmd.apply_sign = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted transaction did not leave idle");

   a_timeout_skips_work: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_timed_out |=> state_ff == ST_FINISH)
      else $error("timed out transaction entered the datapath");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && status.div_last |=> state_ff == ST_SIGN)
      else $error("divider did not hand over after its last step");

endmodule

@@ hdl/amac_datapath.sv @@
// sample ring, running sum, serial divider, calibration multiplier and result register
module amac_datapath #(
   parameter int unsigned WINDOW = amac_pkg::DEFAULT_WINDOW
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  amac_pkg::amac_cmd_type                 cmd,
   output amac_pkg::amac_status_type              status,
   input  logic [amac_pkg::RAW_W-1:0]             req_raw_code,
   input  logic                                   req_timed_out,
   input  logic                                   csr_we,
   input  logic [amac_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [amac_pkg::CFG_W-1:0]             csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_ok,
   output logic signed [amac_pkg::RAW_W-1:0]      rsp_sample_value,
   output logic signed [amac_pkg::OUT_W-1:0]      rsp_filtered_q8,
   output logic signed [amac_pkg::OUT_W-1:0]      rsp_pressure_q8
);
   import amac_pkg::*;

   localparam int unsigned SUM_W  = RAW_W + $clog2(WINDOW);
   localparam int unsigned FILL_W = $clog2(WINDOW + 1);
   localparam int unsigned POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned DIVD_W = SUM_W + Q_FRAC;
   localparam int unsigned CNT_W  = $clog2(DIVD_W + 1);
   localparam int unsigned PROD_W = 2 * CFG_W;
   localparam int unsigned SHR_W  = PROD_W - SCALE_FRAC;
   localparam int unsigned ACC_W  = SHR_W + 1;

   logic signed [CFG_W-1:0]  cal_offset_ff, cal_offset_in;
   logic signed [CFG_W-1:0]  cal_scale_ff, cal_scale_in;
   logic [RAW_W-1:0]         sample_ff;
   logic                     tmo_ff;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [RAW_W-1:0]  rd_data_ff;
   logic [FILL_W-1:0]        rem_ff, rem_in;
   logic [DIVD_W-1:0]        quo_ff, quo_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [OUT_W-1:0]  mean_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [OUT_W-1:0]  pres_ff, pres_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff;
   logic signed [RAW_W-1:0]  rsp_raw_ff;
   logic signed [OUT_W-1:0]  rsp_filt_ff;
   logic signed [OUT_W-1:0]  rsp_pres_ff;

   logic signed [RAW_W-1:0]  ring_mem [WINDOW];

   logic signed [RAW_W-1:0]  sample_s;
   logic signed [SUM_W-1:0]  old_ext;
   logic [SUM_W-1:0]         sum_mag;
   logic [FILL_W:0]          trial;
   logic                     q_bit;
   logic signed [SHR_W-1:0]  shifted;
   logic signed [ACC_W-1:0]  acc;

   assign sample_s = sample_ff;
   assign old_ext  = (fill_ff == FILL_W'(WINDOW)) ? SUM_W'(rd_data_ff) : '0;
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial    = {rem_ff, quo_ff[DIVD_W-1]};
   assign q_bit    = (trial >= {1'b0, fill_ff});
   assign shifted  = prod_ff[PROD_W-1:SCALE_FRAC];
   assign acc      = ACC_W'(shifted) + ACC_W'(cal_offset_ff);

   assign status.div_last = (cnt_ff == CNT_W'(1));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // register writes
   always_comb begin
      cal_offset_in = cal_offset_ff;
      cal_scale_in  = cal_scale_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CAL_OFFSET: cal_offset_in = csr_data;
            CSR_CAL_SCALE:  cal_scale_in  = csr_data;
            default: begin
            end
         endcase
      end
   end

   // ring bookkeeping
   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (cmd.update) begin
         sum_in = sum_ff - old_ext + SUM_W'(sample_s);
         pos_in = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : POS_W'(pos_ff + 1'b1);
         if (fill_ff != FILL_W'(WINDOW)) begin
            fill_in = FILL_W'(fill_ff + 1'b1);
         end
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = {sum_mag, {Q_FRAC{1'b0}}};
         neg_in = sum_ff[SUM_W-1];
         cnt_in = CNT_W'(DIVD_W);
      end else if (cmd.div_step) begin
         rem_in = q_bit ? FILL_W'(trial - {1'b0, fill_ff}) : FILL_W'(trial);
         quo_in = {quo_ff[DIVD_W-2:0], q_bit};
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   // offset add with saturation
   always_comb begin
      if (!acc[ACC_W-1] && (|acc[ACC_W-2:OUT_W-1])) begin
         pres_in = {1'b0, {(OUT_W-1){1'b1}}};
      end else if (acc[ACC_W-1] && !(&acc[ACC_W-2:OUT_W-1])) begin
         pres_in = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         pres_in = acc[OUT_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_offset_ff <= CAL_OFFSET_RESET;
         cal_scale_ff  <= CAL_SCALE_RESET;
         pos_ff        <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cal_offset_ff <= cal_offset_in;
         cal_scale_ff  <= cal_scale_in;
         pos_ff        <= pos_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ring_mem[pos_ff];
      if (cmd.update) begin
         ring_mem[pos_ff] <= sample_s;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      if (cmd.capture) begin
         sample_ff <= req_raw_code;
         tmo_ff    <= req_timed_out;
      end
      if (cmd.apply_sign) begin
         mean_ff <= neg_ff ? OUT_W'(-quo_ff[OUT_W-1:0]) : quo_ff[OUT_W-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= mean_ff * cal_scale_ff;
      end
      if (cmd.add) begin
         pres_ff <= pres_in;
      end
      if (cmd.out_load) begin
         rsp_ok_ff   <= !tmo_ff;
         rsp_raw_ff  <= tmo_ff ? '0 : sample_s;
         rsp_filt_ff <= tmo_ff ? '0 : mean_ff;
         rsp_pres_ff <= tmo_ff ? '0 : pres_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_sample_value = rsp_raw_ff;
   assign rsp_filtered_q8  = rsp_filt_ff;
   assign rsp_pressure_q8  = rsp_pres_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW))
      else $error("fill count beyond window");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_pos_only_on_update: assert property (@(posedge clock) disable iff (reset)
      !cmd.update |=> $stable(pos_ff) && $stable(sum_ff))
      else $error("ring state moved without an update");

endmodule

@@ tb/adc_moving_average_calibrate_test.sv @@
// self-checking testbench for the moving average calibrator with a predicting scoreboard
module adc_moving_average_calibrate_test;
   timeunit 1ns;
   timeprecision 1ps;
   import amac_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 115;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      logic                    ok;
      logic signed [RAW_W-1:0] sample_value;
      logic signed [OUT_W-1:0] filtered_q8;
      logic signed [OUT_W-1:0] pressure_q8;
   } reading_type;

   class pressure_mean_board;
      logic signed [RAW_W-1:0] ring[DEFAULT_WINDOW];
      int                      slot;
      int                      filled;
      logic signed [26:0]      running_total;
      logic signed [CFG_W-1:0] offset_q8;
      logic signed [CFG_W-1:0] scale_q24;
      reading_type             expected_readings[$];
      int                      failures;

      function new();
         foreach (ring[i]) ring[i] = '0;
         slot          = 0;
         filled        = 0;
         running_total = '0;
         offset_q8     = CAL_OFFSET_RESET;
         scale_q24     = CAL_SCALE_RESET;
         failures      = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] data);
         if (index == CSR_CAL_OFFSET) offset_q8 = data;
         else if (index == CSR_CAL_SCALE) scale_q24 = data;
      endfunction

      function void take_sample(logic [RAW_W-1:0] code, logic timed_out);
         reading_type             r;
         logic signed [RAW_W-1:0] smp;
         longint                  mean_l;
         longint                  prod;
         longint                  p;
         if (timed_out) begin
            r.ok           = 1'b0;
            r.sample_value = '0;
            r.filtered_q8  = '0;
            r.pressure_q8  = '0;
         end else begin
            smp           = code;
            running_total = running_total - ring[slot] + smp;
            ring[slot]    = smp;
            slot          = (slot + 1) % DEFAULT_WINDOW;
            if (filled < DEFAULT_WINDOW) filled++;
            mean_l = (longint'(running_total) * 256) / longint'(filled);
            prod   = mean_l * longint'(scale_q24);
            p      = (prod >>> SCALE_FRAC) + longint'(offset_q8);
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            r.ok           = 1'b1;
            r.sample_value = smp;
            r.filtered_q8  = mean_l[OUT_W-1:0];
            r.pressure_q8  = p[OUT_W-1:0];
         end
         expected_readings.push_back(r);
      endfunction

      function void compare_response(reading_type got);
         reading_type want;
         if (expected_readings.size() == 0) begin
            $error("response transaction with no expectation waiting");
            failures++;
            return;
         end
         want = expected_readings.pop_front();
         if (got.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            failures++;
         end
         if (got.sample_value !== want.sample_value) begin
            $error("sample_value: expected %0d, got %0d", want.sample_value,
                   got.sample_value);
            failures++;
         end
         if (got.filtered_q8 !== want.filtered_q8) begin
            $error("filtered_q8: expected %0d, got %0d", want.filtered_q8, got.filtered_q8);
            failures++;
         end
         if (got.pressure_q8 !== want.pressure_q8) begin
            $error("pressure_q8: expected %0d, got %0d", want.pressure_q8, got.pressure_q8);
            failures++;
         end
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_req = 1'b0;
   int   recv_stall_pct = 0;
   int   send_idle_pct = 0;

   pressure_mean_board board = new();

   amac_req_if req_chan();
   amac_rsp_if rsp_chan();
   amac_csr_if csr_chan();

   adc_moving_average_calibrate DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side, with one long hold-off on request
   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left      = 0;
      hold_done      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // observes every transaction between edges, feeds the scoreboard and guards progress
   initial begin : watchdog
      int          quiet;
      reading_type got;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if (reset) begin
            quiet = 0;
         end else begin
            quiet++;
            if (req_chan.valid && req_chan.ready) begin
               board.take_sample(req_chan.raw_code, req_chan.timed_out);
               quiet = 0;
            end
            if (rsp_chan.valid && rsp_chan.ready) begin
               got.ok           = rsp_chan.ok;
               got.sample_value = rsp_chan.sample_value;
               got.filtered_q8  = rsp_chan.filtered_q8;
               got.pressure_q8  = rsp_chan.pressure_q8;
               board.compare_response(got);
               quiet = 0;
            end
            if (csr_chan.valid && csr_chan.ready) quiet = 0;
         end
      end
      $display("Verification failed");
      $finish;
   end

   task automatic send_reading(input logic [RAW_W-1:0] code, input logic timed_out);
      bit fire;
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid     <= 1'b1;
      req_chan.raw_code  <= code;
      req_chan.timed_out <= timed_out;
      do begin
         @(negedge clock);
         fire = req_chan.ready;
         @(posedge clock);
      end while (!fire);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
      bit fire;
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do begin
         @(negedge clock);
         fire = csr_chan.ready;
         @(posedge clock);
      end while (!fire);
      board.write_register(index, data);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] pick_code();
      case ($urandom_range(7))
         0: return 24'h7F_FFFF;
         1: return 24'h80_0000;
         2: return RAW_W'($urandom_range(15));
         3: return RAW_W'(0 - $urandom_range(1, 16));
         default: return RAW_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic [CFG_W-1:0] offset_w;
      logic [CFG_W-1:0] scale_w;
      req_chan.valid     = 1'b0;
      req_chan.raw_code  = '0;
      req_chan.timed_out = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = '0;
      csr_chan.data      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // timeout on an empty ring, partial fills with inexact means, then full-scale windows
      send_reading(24'hFF_FFFF, 1'b1);
      send_reading(24'h00_0001, 1'b0);
      send_reading(24'hFF_FFFF, 1'b0);
      send_reading(24'hFF_FFFF, 1'b0);
      send_reading(24'h7F_FFFF, 1'b0);
      send_reading(24'h80_0000, 1'b0);
      send_reading(24'h80_0000, 1'b0);
      send_reading(24'hFF_FFFE, 1'b0);
      repeat (8) send_reading(24'h7F_FFFF, 1'b0);
      send_reading(24'h00_0000, 1'b1);
      repeat (8) send_reading(24'h80_0000, 1'b0);
      send_reading(24'h00_0000, 1'b0);
      req_chan.valid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin offset_w = 32'h7FFF_FFFF; scale_w = 32'h7FFF_FFFF; end
            1: begin offset_w = 32'h8000_0000; scale_w = 32'h8000_0000; end
            2: begin offset_w = 32'h0000_0000; scale_w = 32'h0000_0000; end
            3: begin offset_w = 32'h8000_0000; scale_w = 32'h7FFF_FFFF; end
            default: begin
               offset_w = $urandom;
               if (phase % 2 == 0) scale_w = $urandom;
               else scale_w = CAL_SCALE_RESET + $urandom_range(65535) - 32768;
            end
         endcase
         write_csr(CSR_CAL_OFFSET, offset_w);
         write_csr(CSR_CAL_SCALE, scale_w);
         write_csr(CSR_IDX_W'($urandom_range(2, 255)), $urandom);
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct <= 73; end
            default: begin send_idle_pct = 21; recv_stall_pct <= 21; end
         endcase
         if (phase == 4) hold_req <= 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_reading(pick_code(), $urandom_range(9) == 0);
         req_chan.valid <= 1'b0;
      end

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
